@@ hw/rtl/plrs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse link receiver sequencer package
// Shared widths, item kinds, reply kinds and register indexes.
// ----------------------------------------------------------------------------
package plrs_pkg;

	// Field widths
	localparam int IdBits   = 31;
	localparam int StatBits = 31;
	localparam int LenBits  = 16;
	localparam int GapBits  = 10;
	localparam int InactBits = 24;
	localparam int CfgIdxBits = 2;
	localparam int CfgDataBits = 24;

	// Register reset values
	localparam logic [LenBits-1:0]   PulseLenReset = LenBits'(50);
	localparam logic [GapBits-1:0]   MaxGapReset   = GapBits'(10);
	localparam logic [InactBits-1:0] InactReset    = InactBits'(60000);

	// Saturation limits
	localparam logic [StatBits-1:0]  StatMax  = {StatBits{1'b1}};
	localparam logic [LenBits-1:0]   LenMax   = {LenBits{1'b1}};
	localparam logic [InactBits-1:0] InactMax = {InactBits{1'b1}};

	typedef logic [IdBits-1:0]   id_t;
	typedef logic [StatBits-1:0] stat_t;

	// Item kinds
	typedef enum logic [1:0] {
		FUNC_TICK  = 2'd0,
		FUNC_PULSE = 2'd1,
		FUNC_SYNC  = 2'd2,
		FUNC_BOOT  = 2'd3
	} func_t;

	// Reply kinds
	typedef enum logic [1:0] {
		REPLY_NONE   = 2'd0,
		REPLY_ACK    = 2'd1,
		REPLY_BOOT   = 2'd2,
		REPLY_REPORT = 2'd3
	} reply_t;

	// Configuration register indexes
	localparam logic [CfgIdxBits-1:0] CFG_PULSE_LEN = 2'd0;
	localparam logic [CfgIdxBits-1:0] CFG_MAX_GAP   = 2'd1;
	localparam logic [CfgIdxBits-1:0] CFG_INACT     = 2'd2;

	// Saturating add of two statistic values.
	function automatic stat_t stat_sat_add(input stat_t a, input stat_t b);
		logic [StatBits:0] sum;
		begin
			sum = {1'b0, a} + {1'b0, b};
			if (sum >= {1'b0, StatMax}) begin
				stat_sat_add = StatMax;
			end else begin
				stat_sat_add = sum[StatBits-1:0];
			end
		end
	endfunction

	// Larger of two statistic values.
	function automatic stat_t stat_max(input stat_t a, input stat_t b);
		stat_max = (a > b) ? a : b;
	endfunction

endpackage

@@ hw/rtl/pulse_link_receiver_sequencer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse link receiver sequencer
// Tracks pulse ids, drives the output pulse and replays owed pulses.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_ready) carries one request per item:
//   a 1 ms tick, a pulse message, a sync query or a sender boot message.
//   Every request yields exactly one result on the output channel
//   (out_valid / out_ready), holding the pin level, the reply and the
//   link status after that request.
//   The result is valid in the cycle after the request is taken.
//   Throughput is one request per cycle unless stalled; the state and
//   the result register are updated by one pass of compare and add logic.
//   The result register holds one result. A new request is taken while
//   the held result is being taken in the same cycle, so a stalled
//   receiver stalls the input only while the result register is full.
//   The configuration channel (cfg_valid / cfg_ready) is always ready and
//   writes one register per request; write it only while the block idles.
//   Reset clears all state and loads the register defaults: pulse length
//   50, largest buffered gap 10 and inactivity limit 60000 ticks.
// ----------------------------------------------------------------------------
module pulse_link_receiver_sequencer (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [plrs_pkg::CfgIdxBits-1:0]   cfg_index,
	input  logic [plrs_pkg::CfgDataBits-1:0]  cfg_data,
	// Input channel
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        func,
	input  logic [plrs_pkg::IdBits-1:0]       pulse_id,
	input  logic [plrs_pkg::StatBits-1:0]     peer_pulses,
	input  logic [plrs_pkg::StatBits-1:0]     peer_sender_reboots,
	input  logic [plrs_pkg::StatBits-1:0]     peer_receiver_reboots,
	input  logic [plrs_pkg::StatBits-1:0]     peer_lost,
	// Output channel
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              pulse_low,
	output logic [1:0]                        reply_kind,
	output logic [plrs_pkg::StatBits-1:0]     reply_pulses,
	output logic [plrs_pkg::StatBits-1:0]     reply_sender_reboots,
	output logic [plrs_pkg::StatBits-1:0]     reply_receiver_reboots,
	output logic [plrs_pkg::StatBits-1:0]     reply_lost,
	output logic                              link_up,
	output logic [plrs_pkg::StatBits-1:0]     backlog_now,
	output logic [plrs_pkg::StatBits-1:0]     lost_now
);
	import plrs_pkg::*;

	// Configuration registers
	logic [LenBits-1:0]   pulse_len_q;
	logic [GapBits-1:0]   max_gap_q;
	logic [InactBits-1:0] inact_limit_q;

	// Link state
	id_t                  last_id_q;
	logic                 pulse_on_q;
	logic [LenBits-1:0]   since_start_q;
	logic [LenBits-1:0]   since_end_q;
	logic [InactBits-1:0] since_msg_q;
	stat_t                backlog_q;
	stat_t                lost_q;
	logic                 resync_q;
	logic                 connected_q;
	stat_t                st_pulses_q;
	stat_t                st_snd_reboots_q;
	stat_t                st_rcv_reboots_q;
	stat_t                st_lost_q;

	// Next state
	id_t                  last_id_d;
	logic                 pulse_on_d;
	logic [LenBits-1:0]   since_start_d;
	logic [LenBits-1:0]   since_end_d;
	logic [InactBits-1:0] since_msg_d;
	stat_t                backlog_d;
	stat_t                lost_d;
	logic                 resync_d;
	logic                 connected_d;
	stat_t                st_pulses_d;
	stat_t                st_snd_reboots_d;
	stat_t                st_rcv_reboots_d;
	stat_t                st_lost_d;

	// Reply of this request
	reply_t               kind_d;
	stat_t                r_pulses_d;
	stat_t                r_snd_d;
	stat_t                r_rcv_d;
	stat_t                r_lost_d;

	logic                 in_accept;
	logic [IdBits:0]      next_id;
	logic [IdBits:0]      id_ext;
	stat_t                gap;
	stat_t                snd_merged;
	func_t                func_e;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid || out_ready;
	assign in_accept = in_valid && in_ready;
	assign func_e    = func_t'(func);

	// Id sequence helpers
	assign next_id    = {1'b0, last_id_q} + (IdBits+1)'(1);
	assign id_ext     = {1'b0, pulse_id};
	assign gap        = StatBits'(id_ext - next_id);
	assign snd_merged = stat_max(st_snd_reboots_q, peer_sender_reboots);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_len_q   <= PulseLenReset;
			max_gap_q     <= MaxGapReset;
			inact_limit_q <= InactReset;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_PULSE_LEN: pulse_len_q   <= cfg_data[LenBits-1:0];
				CFG_MAX_GAP:   max_gap_q     <= cfg_data[GapBits-1:0];
				CFG_INACT:     inact_limit_q <= cfg_data[InactBits-1:0];
				default: ;
			endcase
		end
	end

	// Per-request state update and reply
	always_comb begin
		last_id_d        = last_id_q;
		pulse_on_d       = pulse_on_q;
		since_start_d    = since_start_q;
		since_end_d      = since_end_q;
		since_msg_d      = since_msg_q;
		backlog_d        = backlog_q;
		lost_d           = lost_q;
		resync_d         = resync_q;
		connected_d      = connected_q;
		st_pulses_d      = st_pulses_q;
		st_snd_reboots_d = st_snd_reboots_q;
		st_rcv_reboots_d = st_rcv_reboots_q;
		st_lost_d        = st_lost_q;
		kind_d           = REPLY_NONE;
		r_pulses_d       = '0;
		r_snd_d          = '0;
		r_rcv_d          = '0;
		r_lost_d         = '0;

		case (func_e)
			FUNC_TICK: begin
				// Timers advance and saturate.
				if (since_start_q != LenMax) since_start_d = since_start_q + LenBits'(1);
				if (since_end_q != LenMax) since_end_d = since_end_q + LenBits'(1);
				if (since_msg_q != InactMax) since_msg_d = since_msg_q + InactBits'(1);
				// A pulse that has run its length ends.
				if (pulse_on_q && since_start_d >= pulse_len_q) begin
					pulse_on_d  = 1'b0;
					since_end_d = '0;
				end
				if (since_msg_d > inact_limit_q) connected_d = 1'b0;
				// Replay one owed pulse once the idle gap has passed.
				if (backlog_q != '0 && !pulse_on_d && since_end_d > pulse_len_q) begin
					pulse_on_d    = 1'b1;
					since_start_d = '0;
					backlog_d     = backlog_q - StatBits'(1);
				end
			end
			FUNC_PULSE: begin
				connected_d = 1'b1;
				if (id_ext == next_id) begin
					// Next id in sequence: play now or defer to the backlog.
					last_id_d   = pulse_id;
					since_msg_d = '0;
					if (pulse_on_q || since_end_q < pulse_len_q) begin
						backlog_d = stat_sat_add(backlog_q, StatBits'(1));
					end else begin
						pulse_on_d    = 1'b1;
						since_start_d = '0;
					end
				end else if (id_ext > next_id) begin
					// Missed ids: small gaps are owed, large ones are lost.
					if (gap > StatBits'(max_gap_q)) begin
						resync_d = 1'b1;
						lost_d   = stat_sat_add(lost_q, gap);
					end else begin
						backlog_d = stat_sat_add(backlog_q, gap);
					end
					last_id_d     = pulse_id;
					since_msg_d   = '0;
					pulse_on_d    = 1'b1;
					since_start_d = '0;
				end
			end
			FUNC_SYNC: begin
				if (!resync_q) begin
					kind_d      = REPLY_ACK;
					r_pulses_d  = last_id_q;
					connected_d = 1'b1;
				end else begin
					// Resync pending: send a full boot report instead.
					resync_d         = 1'b0;
					st_pulses_d      = last_id_q;
					st_lost_d        = lost_q;
					kind_d           = REPLY_REPORT;
					r_pulses_d       = last_id_q;
					r_snd_d          = st_snd_reboots_q;
					r_rcv_d          = st_rcv_reboots_q;
					r_lost_d         = lost_q;
					st_snd_reboots_d = stat_sat_add(st_snd_reboots_q, StatBits'(1));
				end
			end
			FUNC_BOOT: begin
				// Report own statistics, then merge with the peer's.
				kind_d           = REPLY_BOOT;
				r_pulses_d       = last_id_q;
				r_snd_d          = st_snd_reboots_q;
				r_rcv_d          = st_rcv_reboots_q;
				r_lost_d         = lost_q;
				connected_d      = 1'b1;
				st_pulses_d      = stat_max(last_id_q, peer_pulses);
				st_rcv_reboots_d = stat_max(st_rcv_reboots_q, peer_receiver_reboots);
				st_lost_d        = stat_max(lost_q, peer_lost);
				st_snd_reboots_d = stat_sat_add(snd_merged, StatBits'(1));
				last_id_d        = st_pulses_d;
				lost_d           = st_lost_d;
			end
			default: ;
		endcase
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_id_q        <= '0;
			pulse_on_q       <= 1'b0;
			since_start_q    <= '0;
			since_end_q      <= '0;
			since_msg_q      <= '0;
			backlog_q        <= '0;
			lost_q           <= '0;
			resync_q         <= 1'b0;
			connected_q      <= 1'b0;
			st_pulses_q      <= '0;
			st_snd_reboots_q <= '0;
			st_rcv_reboots_q <= '0;
			st_lost_q        <= '0;
		end else if (in_accept) begin
			last_id_q        <= last_id_d;
			pulse_on_q       <= pulse_on_d;
			since_start_q    <= since_start_d;
			since_end_q      <= since_end_d;
			since_msg_q      <= since_msg_d;
			backlog_q        <= backlog_d;
			lost_q           <= lost_d;
			resync_q         <= resync_d;
			connected_q      <= connected_d;
			st_pulses_q      <= st_pulses_d;
			st_snd_reboots_q <= st_snd_reboots_d;
			st_rcv_reboots_q <= st_rcv_reboots_d;
			st_lost_q        <= st_lost_d;
		end
	end

	// Result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (in_ready) begin
			out_valid <= in_valid;
		end
	end

	// Result payload register
	always_ff @(posedge clk) begin
		if (in_accept) begin
			pulse_low              <= pulse_on_d;
			reply_kind             <= kind_d;
			reply_pulses           <= r_pulses_d;
			reply_sender_reboots   <= r_snd_d;
			reply_receiver_reboots <= r_rcv_d;
			reply_lost             <= r_lost_d;
			link_up                <= connected_d;
			backlog_now            <= backlog_d;
			lost_now               <= lost_d;
		end
	end

	// Every request produces a result in the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> out_valid)
		else $error("request taken without a result");

	// A tick never grows the backlog; it replays at most one owed pulse.
	a_backlog_step: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && func_e == FUNC_TICK |=> backlog_q <= $past(backlog_q))
		else $error("backlog grew on a tick");

	// The resync flag is only raised by a pulse message.
	a_resync_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(resync_q) |-> $past(in_accept && func_e == FUNC_PULSE))
		else $error("resync flag raised by a non-pulse request");

	// A sync query is always answered with an ack or a boot report.
	a_sync_reply: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && func_e == FUNC_SYNC
		|=> reply_kind == REPLY_ACK || reply_kind == REPLY_REPORT)
		else $error("sync query without a proper reply");

	// The lost count falls only through a sender boot merge.
	a_lost_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		lost_q < $past(lost_q) |-> $past(in_accept && func_e == FUNC_BOOT))
		else $error("lost count decreased outside a boot merge");

endmodule
